/* hdl/twb_pkg.sv */
// Shared constants, pipeline stage map and control types for the tile write-back blend.
package twb_pkg;

    // Pipeline stage map: input register, half decode, eight divider steps,
    // blend multiply, packed output register.
    localparam int NUM_STAGES = 12;
    localparam int ST_IN      = 0;
    localparam int ST_DEC     = 1;
    localparam int ST_DIV0    = 2;
    localparam int DIV_STEPS  = 8;
    localparam int ST_WGT     = ST_DIV0 + DIV_STEPS - 1;
    localparam int ST_MUL     = ST_WGT + 1;
    localparam int ST_OUT     = ST_MUL + 1;

    localparam int NUM_LANES  = 4;
    localparam int HALF_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int NUM_W      = 16;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SHARED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_SHARED    = 2'd2;

    // Per-stage load enables, shared by the lanes and the divider.
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

/* hdl/twb_div.sv */
// Pipelined restoring divider, one quotient bit per stage, for the blend weight.
module twb_div (
    input  logic                          i_clk,
    input  twb_pkg::t_pipe_ctl            i_ctl,
    input  logic [twb_pkg::NUM_W-1:0]     i_num,
    input  logic [twb_pkg::BYTE_W-1:0]    i_divisor,
    output logic [twb_pkg::BYTE_W-1:0]    o_quot
);

    typedef struct packed {
        logic [twb_pkg::BYTE_W-1:0] rem;
        logic [twb_pkg::BYTE_W-1:0] lo;
        logic [twb_pkg::BYTE_W-1:0] q;
    } t_div_st;

    // Shift in the next numerator bit, subtract the divisor when it fits.
    function automatic t_div_st div_step(t_div_st s, logic [twb_pkg::BYTE_W-1:0] d);
        logic [twb_pkg::BYTE_W:0] sh;
        logic                     ge;
        t_div_st                  o;
        sh    = {s.rem, s.lo[twb_pkg::BYTE_W-1]};
        ge    = (sh >= {1'b0, d});
        o.rem = ge ? twb_pkg::BYTE_W'(sh - {1'b0, d}) : sh[twb_pkg::BYTE_W-1:0];
        o.lo  = {s.lo[twb_pkg::BYTE_W-2:0], 1'b0};
        o.q   = {s.q[twb_pkg::BYTE_W-2:0], ge};
        return o;
    endfunction

    t_div_st r_st [twb_pkg::DIV_STEPS];
    t_div_st w_first;

    // Quotient is below 256 because the numerator's upper byte is below the divisor.
    assign w_first = '{rem: i_num[twb_pkg::NUM_W-1:twb_pkg::BYTE_W],
                       lo:  i_num[twb_pkg::BYTE_W-1:0],
                       q:   '0};

    for (genvar g = 0; g < twb_pkg::DIV_STEPS; g++) begin : g_step
        if (g == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_ctl.en[twb_pkg::ST_DIV0]) begin
                    r_st[g] <= div_step(w_first, i_divisor);
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (i_ctl.en[twb_pkg::ST_DIV0 + g]) begin
                    r_st[g] <= div_step(r_st[g-1], i_divisor);
                end
            end
        end
    end

    assign o_quot = r_st[twb_pkg::DIV_STEPS-1].q;

endmodule

/* hdl/twb_lane.sv */
// One colour lane: half-to-byte conversion, delay to the weight, and cross-fade.
module twb_lane (
    input  logic                          i_clk,
    input  twb_pkg::t_pipe_ctl            i_ctl,
    input  logic [twb_pkg::HALF_W-1:0]    i_half,
    input  logic [twb_pkg::BYTE_W-1:0]    i_old,
    input  logic [twb_pkg::BYTE_W-1:0]    i_weight,
    output logic [twb_pkg::BYTE_W-1:0]    o_plain,
    output logic [twb_pkg::BYTE_W-1:0]    o_blend
);

    // Input stage
    logic [twb_pkg::HALF_W-1:0] r_half;
    // Old byte travels from the decode stage to the weight stage
    logic [twb_pkg::BYTE_W-1:0] r_old [twb_pkg::ST_DEC:twb_pkg::ST_WGT];
    logic [twb_pkg::BYTE_W-1:0] r_old_in;
    // Decode stage
    logic        r_neg;
    logic        r_big;
    logic [4:0]  r_sh;
    logic [18:0] r_x;
    // New byte from the rounding stage onwards
    logic [twb_pkg::BYTE_W-1:0] r_nb [twb_pkg::ST_DIV0:twb_pkg::ST_WGT];
    // Multiply stage
    logic [15:0] r_vo;
    logic [15:0] r_vn;
    logic [twb_pkg::BYTE_W-1:0] r_nb_mul;

    logic [4:0]  w_exp;
    logic [4:0]  w_exp_eff;
    logic [10:0] w_mag;
    logic [24:0] w_rnd;
    logic [24:0] w_sum;
    logic [24:0] w_shd;
    logic [twb_pkg::BYTE_W-1:0] w_byte;
    logic [twb_pkg::BYTE_W-1:0] w_winv;
    logic [15:0] w_mo;
    logic [15:0] w_mn;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[twb_pkg::ST_IN]) begin
            r_half   <= i_half;
            r_old_in <= i_old;
        end
    end

    // Decode: value = mag * 2^(exp - 25); exponent 31 is an ordinary normal.
    always_comb begin
        w_exp     = r_half[14:10];
        w_mag     = (w_exp != 5'd0) ? {1'b1, r_half[9:0]} : {1'b0, r_half[9:0]};
        w_exp_eff = (w_exp == 5'd0) ? 5'd1 : w_exp;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[twb_pkg::ST_DEC]) begin
            r_neg              <= r_half[15];
            r_big              <= (w_exp_eff >= 5'd25);
            r_sh               <= 5'd25 - w_exp_eff;
            r_x                <= {w_mag, 8'h00} - {8'h00, w_mag};
            r_old[twb_pkg::ST_DEC] <= r_old_in;
        end
    end

    // Round half up, then clamp; negatives drop to zero, big positive exponents saturate.
    always_comb begin
        w_rnd = 25'd1 << (r_sh - 5'd1);
        w_sum = {6'h00, r_x} + w_rnd;
        w_shd = w_sum >> r_sh;
        if (r_neg) begin
            w_byte = '0;
        end else if (r_big || (|w_shd[24:8])) begin
            w_byte = 8'hFF;
        end else begin
            w_byte = w_shd[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[twb_pkg::ST_DIV0]) begin
            r_nb[twb_pkg::ST_DIV0] <= w_byte;
        end
    end

    for (genvar k = twb_pkg::ST_DIV0; k <= twb_pkg::ST_WGT; k++) begin : g_old
        always_ff @(posedge i_clk) begin
            if (i_ctl.en[k]) begin
                r_old[k] <= r_old[k-1];
            end
        end
    end

    for (genvar k = twb_pkg::ST_DIV0 + 1; k <= twb_pkg::ST_WGT; k++) begin : g_nb
        always_ff @(posedge i_clk) begin
            if (i_ctl.en[k]) begin
                r_nb[k] <= r_nb[k-1];
            end
        end
    end

    assign w_winv = 8'hFF - i_weight;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[twb_pkg::ST_MUL]) begin
            r_vo     <= ({8'h00, r_old[twb_pkg::ST_WGT]} * {8'h00, w_winv}) + 16'd128;
            r_vn     <= ({8'h00, r_nb[twb_pkg::ST_WGT]} * {8'h00, i_weight}) + 16'd128;
            r_nb_mul <= r_nb[twb_pkg::ST_WGT];
        end
    end

    // Divide by 255 with rounding: (v + (v >> 8)) >> 8, never past 16 bits.
    assign w_mo    = r_vo + {8'h00, r_vo[15:8]};
    assign w_mn    = r_vn + {8'h00, r_vn[15:8]};
    assign o_blend = w_mo[15:8] + w_mn[15:8];
    assign o_plain = r_nb_mul;

endmodule

/* hdl/tile_writeback_half_overlap_blend.sv */
// Top level: stream handshake, configuration registers, band test and output merge.
//
// Tile write-back with a linear seam blend. One input request carries a pixel:
// four half-float channel codes, the four destination bytes now in memory, and
// the pixel's column and row within the tile. One result request comes back per
// pixel with four bytes to write and an in-band flag on tuser.
//
// Configuration: write overlap width (index 0), left shared (1) and top shared
// (2) on the cfg channel while no pixel is in flight; it is always ready.
//
// Timing: twelve register stages; one pixel is taken every cycle unless every
// stage is occupied and the receiver holds tready low. The depth is set by the
// weight divider, which resolves one quotient bit per stage over 8 stages.
//
// Reset (synchronous, active low) empties the pipeline and clears the three
// registers to zero. Each stage holds its request while the next is full and
// stalled; empty stages keep filling, so s_axis_tready drops only once every
// stage is occupied and the receiver holds tready low.
module tile_writeback_half_overlap_blend (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // cfg channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [twb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [twb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // pixel in
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // red_half, green_half, blue_half, alpha_half (16 each), old_red, old_green,
    // old_blue, old_alpha, tile_col, tile_row (8 each)
    input  logic [twb_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // bytes out
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // red_out, green_out, blue_out, alpha_out (8 each)
    output logic [twb_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // in_band
    output logic                               o_m_axis_tuser
);

    localparam int LAST = twb_pkg::NUM_STAGES - 1;

    // Configuration registers
    logic [twb_pkg::BYTE_W-1:0] r_ow;
    logic                       r_left;
    logic                       r_top;

    // Control
    logic [twb_pkg::NUM_STAGES-1:0] r_vld;
    logic [twb_pkg::NUM_STAGES-1:0] n_vld;
    logic [twb_pkg::NUM_STAGES-1:0] w_rdy;
    logic [twb_pkg::NUM_STAGES-1:0] w_vin;
    twb_pkg::t_pipe_ctl             w_ctl;

    // Position and band
    logic [twb_pkg::BYTE_W-1:0]     r_col;
    logic [twb_pkg::BYTE_W-1:0]     r_row;
    logic [twb_pkg::NUM_W-1:0]      r_num;
    logic                           r_band [twb_pkg::ST_DEC:twb_pkg::ST_MUL];
    logic                           w_band;
    logic [twb_pkg::BYTE_W-1:0]     w_pos;
    logic [twb_pkg::BYTE_W-1:0]     w_weight;

    // Output register
    logic [twb_pkg::OUT_DATA_W-1:0] r_tdata;
    logic                           r_tuser;

    // Lane results
    logic [twb_pkg::BYTE_W-1:0]     w_plain [twb_pkg::NUM_LANES];
    logic [twb_pkg::BYTE_W-1:0]     w_blend [twb_pkg::NUM_LANES];
    logic [twb_pkg::OUT_DATA_W-1:0] w_plain_pk;
    logic [twb_pkg::OUT_DATA_W-1:0] w_blend_pk;

    // ------------------------------------------------------------------
    // Configuration: always accept, ignore indexes past the list.
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ow   <= '0;
            r_left <= 1'b0;
            r_top  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                twb_pkg::CFG_OVERLAP_WIDTH: r_ow   <= i_cfg_data;
                twb_pkg::CFG_LEFT_SHARED:   r_left <= i_cfg_data[0];
                twb_pkg::CFG_TOP_SHARED:    r_top  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its occupant moves on.
    // ------------------------------------------------------------------
    assign w_vin = {r_vld[LAST-1:0], i_s_axis_tvalid};
    assign w_rdy[LAST] = !r_vld[LAST] || i_m_axis_tready;

    for (genvar k = 0; k < LAST; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    assign w_ctl.en = w_rdy & w_vin;
    assign n_vld    = (w_rdy & w_vin) | (~w_rdy & r_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = w_rdy[twb_pkg::ST_IN];

    // ------------------------------------------------------------------
    // Band test and weight numerator p*255.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[twb_pkg::ST_IN]) begin
            r_col <= i_s_axis_tdata[103:96];
            r_row <= i_s_axis_tdata[111:104];
        end
    end

    always_comb begin
        w_band = (r_left && (r_col < r_ow)) || (r_top && (r_row < r_ow));
        priority if (!r_left) begin
            w_pos = r_row;
        end else if (!r_top) begin
            w_pos = r_col;
        end else begin
            w_pos = (r_col < r_row) ? r_col : r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[twb_pkg::ST_DEC]) begin
            r_num                   <= {w_pos, 8'h00} - {8'h00, w_pos};
            r_band[twb_pkg::ST_DEC] <= w_band;
        end
    end

    // Carry the band flag alongside the divider and the multiply stage.
    for (genvar k = twb_pkg::ST_DIV0; k <= twb_pkg::ST_MUL; k++) begin : g_band
        always_ff @(posedge i_clk) begin
            if (w_ctl.en[k]) begin
                r_band[k] <= r_band[k-1];
            end
        end
    end

    // Weight = floor(p*255 / overlap); only used inside the band, where p < overlap.
    twb_div u_div (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_num     (r_num),
        .i_divisor (r_ow),
        .o_quot    (w_weight)
    );

    // ------------------------------------------------------------------
    // Four colour lanes side by side.
    // ------------------------------------------------------------------
    for (genvar l = 0; l < twb_pkg::NUM_LANES; l++) begin : g_lane
        twb_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_half   (i_s_axis_tdata[l*twb_pkg::HALF_W +: twb_pkg::HALF_W]),
            .i_old    (i_s_axis_tdata[twb_pkg::NUM_LANES*twb_pkg::HALF_W +
                                      l*twb_pkg::BYTE_W +: twb_pkg::BYTE_W]),
            .i_weight (w_weight),
            .o_plain  (w_plain[l]),
            .o_blend  (w_blend[l])
        );
        assign w_plain_pk[l*twb_pkg::BYTE_W +: twb_pkg::BYTE_W] = w_plain[l];
        assign w_blend_pk[l*twb_pkg::BYTE_W +: twb_pkg::BYTE_W] = w_blend[l];
    end

    // ------------------------------------------------------------------
    // Merge: pick blended or plain bytes for all lanes, register the result.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[twb_pkg::ST_OUT]) begin
            r_tdata <= r_band[twb_pkg::ST_MUL] ? w_blend_pk : w_plain_pk;
            r_tuser <= r_band[twb_pkg::ST_MUL];
        end
    end

    assign o_m_axis_tvalid = r_vld[LAST];
    assign o_m_axis_tdata  = r_tdata;
    assign o_m_axis_tuser  = r_tuser;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_band_needs_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (r_left || r_top))
        else $error("blended pixel with no shared edge");

    a_band_needs_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (r_ow != '0))
        else $error("blended pixel with zero overlap");

    a_weight_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[twb_pkg::ST_WGT] && r_band[twb_pkg::ST_WGT]) |-> (w_weight != 8'hFF))
        else $error("blend weight reached full scale");

    a_empty_front_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[twb_pkg::ST_IN] |-> o_s_axis_tready)
        else $error("input stalled with an empty front stage");

    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_m_axis_tready) |=> $stable(r_vld))
        else $error("full pipeline moved while output stalled");

endmodule

/* sim/tile_writeback_half_overlap_blend_test.sv */
`timescale 1ns / 1ps
// Self-checking stream testbench for the tile write-back seam blend, directed table then random.
module tile_writeback_half_overlap_blend_test;

    // Index on the configuration channel with no register behind it: writes must be ignored.
    localparam logic [twb_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // Cycles to hold off after the last result before touching the registers or finishing.
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 50;

    // One pixel request as it lies on tdata, red channel in the lowest bits.
    typedef struct packed {
        logic [7:0]       row;
        logic [7:0]       col;
        logic [3:0][7:0]  old;   // destination bytes: red, green, blue, alpha from [0] up
        logic [3:0][15:0] half;  // channel half codes: red, green, blue, alpha from [0] up
    } t_pixel;

    // One result request: tuser on top of tdata.
    typedef struct packed {
        logic            band;
        logic [3:0][7:0] bytes;
    } t_wr;

    // Expectation typed into the table, or a request for the blend predictor.
    typedef struct packed {
        logic known;
        t_wr  want;
    } t_tag;

    typedef struct packed {
        logic [7:0] ow;
        logic       lft;
        logic       top;
        t_tag       tag;
        t_pixel     px;
    } t_row;

    logic                                 i_clk           = 1'b0;
    logic                                 i_rst_n         = 1'b0;
    logic                                 i_cfg_valid     = 1'b0;
    logic                                 o_cfg_ready;
    logic [twb_pkg::CFG_IDX_W-1:0]        i_cfg_index     = '0;
    logic [twb_pkg::CFG_DATA_W-1:0]       i_cfg_data      = '0;
    logic                                 i_s_axis_tvalid = 1'b0;
    logic                                 o_s_axis_tready;
    logic [twb_pkg::IN_DATA_W-1:0]        i_s_axis_tdata  = '0;
    logic                                 o_m_axis_tvalid;
    logic                                 i_m_axis_tready = 1'b0;
    logic [twb_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata;
    logic                                 o_m_axis_tuser;

    // Register copy seen by the predictor, updated from the configuration handshakes.
    logic [7:0] seam_w    = 8'd0;
    logic       seam_left = 1'b0;
    logic       seam_top  = 1'b0;

    // Setting last programmed by the stimulus.
    logic [7:0] set_w    = 8'd0;
    logic       set_left = 1'b0;
    logic       set_top  = 1'b0;

    t_wr   pending_writes[$];  // results owed by the block, oldest first
    t_tag  row_tags[$];        // one per pixel driven, consumed on acceptance
    t_row  table_rows[$];
    int    faults = 0;
    logic  calm   = 1'b0;      // set for the last phase: no idling on either side
    string lane_name[4] = '{"red", "green", "blue", "alpha"};

    tile_writeback_half_overlap_blend i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Half code to byte: floor(v*255 + 0.5), clamped. No infinities: exponent 31 is a
    // plain normal. Anything with the sign set, negative zero too, drops to 0.
    function automatic logic [7:0] half_code_to_byte(input logic [15:0] code);
        logic [4:0]  ex;
        logic [31:0] mag;
        logic [31:0] rounded;
        int          sh;
        if (code[15])
            return 8'd0;
        ex  = code[14:10];
        mag = {21'd0, ex != 5'd0, code[9:0]};
        if (ex == 5'd0)
            ex = 5'd1;  // subnormals share the scale of the smallest normal
        if (ex >= 5'd25)
            return 8'hFF;  // hidden bit set, so the value is at least 1024
        sh      = 25 - ex;
        rounded = (mag * 32'd255 + (32'd1 << (sh - 1))) >> sh;
        return (rounded > 32'd255) ? 8'hFF : rounded[7:0];
    endfunction

    // a*b/255 rounded, by the add-and-shift trick.
    function automatic logic [7:0] frac_mul(input logic [7:0] a, input logic [7:0] b);
        logic [31:0] v;
        v = a * b + 32'd128;
        v = (v + (v >> 8)) >> 8;
        return v[7:0];
    endfunction

    function automatic t_wr blend_pixel(input t_pixel px);
        t_wr         res;
        logic [7:0]  pos;
        logic [7:0]  wt;
        logic [7:0]  nb;
        logic [31:0] ramp;
        wt       = 8'd0;
        res.band = (seam_left && px.col < seam_w) || (seam_top && px.row < seam_w);
        // In band implies a nonzero width, so the division is always defined.
        if (res.band) begin
            if (!seam_left)
                pos = px.row;
            else if (!seam_top)
                pos = px.col;
            else
                pos = (px.col < px.row) ? px.col : px.row;
            ramp = pos * 32'd255 / seam_w;
            wt   = ramp[7:0];
        end
        for (int i = 0; i < 4; i++) begin
            nb = half_code_to_byte(px.half[i]);
            // Cross-fade wraps modulo 256.
            res.bytes[i] = res.band ? frac_mul(px.old[i], 8'd255 - wt) + frac_mul(nb, wt) : nb;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic t_pixel pix(input logic [15:0] r, g, b, a,
                                   input logic [7:0] o_r, o_g, o_b, o_a, col, row);
        t_pixel px;
        px.half = {a, b, g, r};
        px.old  = {o_a, o_b, o_g, o_r};
        px.col  = col;
        px.row  = row;
        return px;
    endfunction

    function automatic t_tag written(input logic band, input logic [7:0] r, g, b, a);
        t_tag t;
        t.known      = 1'b1;
        t.want.band  = band;
        t.want.bytes = {a, b, g, r};
        return t;
    endfunction

    task automatic add_row(input logic [7:0] ow, input logic lft, top,
                           input t_pixel px, input t_tag tag);
        t_row r;
        r.ow  = ow;
        r.lft = lft;
        r.top = top;
        r.tag = tag;
        r.px  = px;
        table_rows.push_back(r);
    endtask

    // Mostly positive codes below 2.0, where the byte mapping has something to do;
    // the rest covers every bit, negatives and the saturating top.
    function automatic logic [15:0] rand_half();
        case ($urandom_range(0, 9))
            0, 1:    return 16'($urandom);
            2:       return {1'b1, 15'($urandom)};
            default: return {1'b0, 5'($urandom_range(0, 15)), 10'($urandom)};
        endcase
    endfunction

    // Bias positions into the seam band so blending is hit often.
    function automatic logic [7:0] rand_pos(input logic [7:0] span);
        if (span != 8'd0 && $urandom_range(0, 9) < 7)
            return 8'($urandom_range(0, span));
        return 8'($urandom);
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel px;
        for (int i = 0; i < 4; i++) begin
            px.half[i] = rand_half();
            px.old[i]  = 8'($urandom);
        end
        px.col = rand_pos(set_w);
        px.row = rand_pos(set_w);
        return px;
    endfunction

    // Offer one pixel request and hold it until taken. Valid stays high afterwards,
    // so back-to-back requests never drop it; it is lowered only for a gap.
    task automatic send_pixel(input t_pixel px, input t_tag tag);
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        row_tags.push_back(tag);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Drop valid, wait for every owed result, then let the pipeline run dry.
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0 || row_tags.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write every register, plus the spare index. Flag writes carry random upper bits,
    // which the block must ignore.
    task automatic write_regs(input logic [7:0] ow, input logic lft, top);
        logic [twb_pkg::CFG_IDX_W-1:0]  idx;
        logic [twb_pkg::CFG_DATA_W-1:0] val;
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: begin
                    idx = twb_pkg::CFG_OVERLAP_WIDTH;
                    val = ow;
                end
                1: begin
                    idx = twb_pkg::CFG_LEFT_SHARED;
                    val = {7'($urandom), lft};
                end
                2: begin
                    idx = twb_pkg::CFG_TOP_SHARED;
                    val = {7'($urandom), top};
                end
                default: begin
                    idx = CFG_SPARE;
                    val = 8'($urandom);
                end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        set_w    = ow;
        set_left = lft;
        set_top  = top;
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: track registers, predict on acceptance, check on delivery
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_tag tag;
        t_wr  want;
        t_wr  got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    twb_pkg::CFG_OVERLAP_WIDTH: seam_w    = i_cfg_data;
                    twb_pkg::CFG_LEFT_SHARED:   seam_left = i_cfg_data[0];
                    twb_pkg::CFG_TOP_SHARED:    seam_top  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                tag = row_tags.pop_front();
                pending_writes.push_back(tag.known ? tag.want : blend_pixel(i_s_axis_tdata));
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = {o_m_axis_tuser, o_m_axis_tdata};
                if (pending_writes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h", $time, got);
                    faults++;
                end else begin
                    want = pending_writes.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (got.bytes[i] != want.bytes[i]) begin
                            $display("%0t: %s_out mismatch, expected %0d, got %0d",
                                     $time, lane_name[i], want.bytes[i], got.bytes[i]);
                            faults++;
                        end
                    end
                    if (got.band != want.band) begin
                        $display("%0t: in_band mismatch, expected %0d, got %0d",
                                 $time, want.band, got.band);
                        faults++;
                    end
                end
            end
        end
    end

    // Receiver: random stalls between runs of ready.
    initial begin : sink
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 7) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_row       r;
        logic [7:0] ow;
        logic       lft;
        logic       top;

        // Registers at reset value: plain byte mapping, never in band.
        add_row(8'd0, 1'b0, 1'b0,
                pix(16'h0000, 16'h8000, 16'h3C00, 16'h3800,
                    8'hA5, 8'h5A, 8'hFF, 8'h00, 8'd0, 8'd0),
                written(1'b0, 8'd0, 8'd0, 8'd255, 8'd128));
        add_row(8'd0, 1'b0, 1'b0,
                pix(16'h7FFF, 16'hFFFF, 16'h7C00, 16'h03FF,
                    8'h00, 8'hFF, 8'h00, 8'hFF, 8'd255, 8'd255),
                written(1'b0, 8'd255, 8'd0, 8'd255, 8'd0));
        add_row(8'd0, 1'b0, 1'b0,
                pix(16'h0001, 16'h1C00, 16'h2C00, 16'h5BF8,
                    8'h01, 8'h02, 8'h03, 8'h04, 8'd7, 8'd9),
                written(1'b0, 8'd0, 8'd1, 8'd16, 8'd255));
        add_row(8'd0, 1'b0, 1'b0,
                pix(16'h0400, 16'h8001, 16'h3400, 16'h3A00,
                    8'h80, 8'h40, 8'h20, 8'h10, 8'd0, 8'd255),
                written(1'b0, 8'd0, 8'd0, 8'd64, 8'd191));
        // Zero overlap with both edges shared: nothing blends.
        add_row(8'd0, 1'b1, 1'b1,
                pix(16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00,
                    8'h12, 8'h34, 8'h56, 8'h78, 8'd0, 8'd0),
                written(1'b0, 8'd255, 8'd255, 8'd255, 8'd255));
        // Widest band, both edges: zero weight keeps the old bytes; far corner is outside.
        add_row(8'd255, 1'b1, 1'b1,
                pix(16'h3C00, 16'h0000, 16'h3800, 16'h7FFF,
                    8'h11, 8'h22, 8'h33, 8'h44, 8'd0, 8'd0),
                written(1'b1, 8'h11, 8'h22, 8'h33, 8'h44));
        add_row(8'd255, 1'b1, 1'b1,
                pix(16'h3C00, 16'h0000, 16'h3800, 16'h3A00,
                    8'h00, 8'hFF, 8'h40, 8'hC0, 8'd254, 8'd254),
                '0);
        add_row(8'd255, 1'b1, 1'b1,
                pix(16'h3C00, 16'h0000, 16'h3800, 16'hFFFF,
                    8'h99, 8'h99, 8'h99, 8'h99, 8'd255, 8'd255),
                written(1'b0, 8'd255, 8'd0, 8'd128, 8'd0));
        add_row(8'd255, 1'b1, 1'b1,
                pix(16'h3C00, 16'h3C00, 16'h3C00, 16'h3C00,
                    8'hDE, 8'hAD, 8'hBE, 8'hEF, 8'd0, 8'd200),
                written(1'b1, 8'hDE, 8'hAD, 8'hBE, 8'hEF));
        // One-pixel band on the left edge only.
        add_row(8'd1, 1'b1, 1'b0,
                pix(16'h3C00, 16'h3C00, 16'h0000, 16'h0000,
                    8'h0F, 8'hF0, 8'h55, 8'hAA, 8'd0, 8'd255),
                written(1'b1, 8'h0F, 8'hF0, 8'h55, 8'hAA));
        add_row(8'd1, 1'b1, 1'b0,
                pix(16'h3C00, 16'h3C00, 16'h0000, 16'h0000,
                    8'h0F, 8'hF0, 8'h55, 8'hAA, 8'd1, 8'd0),
                written(1'b0, 8'd255, 8'd255, 8'd0, 8'd0));
        // Top edge only: weight follows the row.
        add_row(8'd16, 1'b0, 1'b1,
                pix(16'h3C00, 16'h3800, 16'h3400, 16'h0000,
                    8'h00, 8'h00, 8'hFF, 8'hFF, 8'd0, 8'd15),
                '0);
        add_row(8'd16, 1'b0, 1'b1,
                pix(16'h3C00, 16'h3800, 16'h3400, 16'h0000,
                    8'h00, 8'h00, 8'hFF, 8'hFF, 8'd3, 8'd16),
                written(1'b0, 8'd255, 8'd128, 8'd64, 8'd0));
        add_row(8'd16, 1'b0, 1'b1,
                pix(16'h3A00, 16'h2C00, 16'h1C00, 16'h3BFF,
                    8'h7F, 8'h80, 8'h01, 8'hFE, 8'd200, 8'd8),
                '0);
        // Both edges, band reached from either side; weight from the nearer edge.
        add_row(8'd128, 1'b1, 1'b1,
                pix(16'h3C00, 16'h3555, 16'h2E66, 16'h8000,
                    8'h20, 8'h40, 8'h60, 8'h80, 8'd10, 8'd200),
                '0);
        add_row(8'd128, 1'b1, 1'b1,
                pix(16'h3C00, 16'h3555, 16'h2E66, 16'h8000,
                    8'h20, 8'h40, 8'h60, 8'h80, 8'd200, 8'd100),
                '0);
        add_row(8'd128, 1'b1, 1'b1,
                pix(16'h3800, 16'h3800, 16'h3800, 16'h3800,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd127, 8'd127),
                '0);
        // Largest weight the band allows.
        add_row(8'd255, 1'b1, 1'b0,
                pix(16'h3C00, 16'h0000, 16'h3C00, 16'h0000,
                    8'h00, 8'hFF, 8'hFF, 8'h00, 8'd254, 8'd0),
                '0);

        // Hold reset, then release it for good.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table: reprogram only where the setting changes.
        foreach (table_rows[n]) begin
            r = table_rows[n];
            if (r.ow != set_w || r.lft != set_left || r.top != set_top) begin
                settle();
                write_regs(r.ow, r.lft, r.top);
            end
            send_pixel(r.px, r.tag);
        end

        // Random phases: fixed settings first, register extremes among them, then random settings.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin ow = 8'd8;   lft = 1'b1; top = 1'b1; end
                1: begin ow = 8'd0;   lft = 1'b1; top = 1'b1; end
                2: begin ow = 8'd255; lft = 1'b1; top = 1'b1; end
                3: begin ow = 8'd1;   lft = 1'b0; top = 1'b1; end
                4: begin ow = 8'd64;  lft = 1'b1; top = 1'b0; end
                default: begin
                    ow  = 8'($urandom);
                    lft = 1'($urandom);
                    top = 1'($urandom);
                end
            endcase
            settle();
            write_regs(ow, lft, top);
            calm = (ph == PHASES - 1);
            repeat (PHASE_ITEMS) send_pixel(rand_pixel(), '0);
        end

        settle();
        if (faults == 0)
            $display("tile_writeback_half_overlap_blend regression: pass");
        else
            $display("tile_writeback_half_overlap_blend regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("tile_writeback_half_overlap_blend regression: fail");
        $finish;
    end

endmodule
